/* rtl/m4vt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// m4vt_pkg: shared definitions for the 4x4 matrix vector transform
// Widths, register indexes and the types passed between the top level and
// the row units.
// ----------------------------------------------------------------------------
package m4vt_pkg;

  localparam int ELEM_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int VEC_WIDTH  = 16;
  localparam int ROW_WIDTH  = 64;
  localparam int NUM_ROWS   = 4;
  localparam int NUM_COLS   = 4;

  localparam int PROD_WIDTH = ELEM_WIDTH + VEC_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  typedef enum logic [1:0] {
    CFG_ROW0 = 2'd0,
    CFG_ROW1 = 2'd1,
    CFG_ROW2 = 2'd2,
    CFG_ROW3 = 2'd3
  } cfg_idx_t;

  typedef logic [NUM_COLS-1:0][VEC_WIDTH-1:0] vec_t;

  typedef struct packed {
    logic [VEC_WIDTH-1:0] value;
    logic                 sat;
  } row_res_t;

  localparam logic [ROW_WIDTH-1:0] ROW0_RESET = ROW_WIDTH'(64'h0000_0000_0000_0100);
  localparam logic [ROW_WIDTH-1:0] ROW1_RESET = ROW_WIDTH'(64'h0000_0000_0100_0000);
  localparam logic [ROW_WIDTH-1:0] ROW2_RESET = ROW_WIDTH'(64'h0000_0100_0000_0000);
  localparam logic [ROW_WIDTH-1:0] ROW3_RESET = ROW_WIDTH'(64'h0100_0000_0000_0000);

endpackage
`default_nettype wire

/* rtl/m4vt_row_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// m4vt_row_unit: one matrix row times the vector
// Registers the four element products, then sums them, floors away the
// fraction bits and clamps the result to the signed 16-bit range.
// ----------------------------------------------------------------------------
module m4vt_row_unit (
  input  logic              clk,
  input  logic              en,
  input  logic [m4vt_pkg::ROW_WIDTH-1:0] row,
  input  m4vt_pkg::vec_t    vec,
  output m4vt_pkg::row_res_t res
);
  import m4vt_pkg::*;

  localparam int ExtWidth = ROW_WIDTH + NUM_COLS * ELEM_WIDTH;
  localparam logic signed [SUM_WIDTH-1:0] SatMax = SUM_WIDTH'(32767);
  localparam logic signed [SUM_WIDTH-1:0] SatMin = -SUM_WIDTH'(32768);

  // Element bits above the top of the row read as zero.
  logic [ExtWidth-1:0] row_ext;
  logic signed [PROD_WIDTH-1:0] prod_r [NUM_COLS];
  logic signed [SUM_WIDTH-1:0]  sum;
  logic signed [SUM_WIDTH-1:0]  shifted;

  assign row_ext = {{(ExtWidth - ROW_WIDTH){1'b0}}, row};

  for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
    logic signed [ELEM_WIDTH-1:0] elem;
    assign elem = $signed(row_ext[c*ELEM_WIDTH +: ELEM_WIDTH]);
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[c] <= elem * $signed(vec[c]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      sum = sum + SUM_WIDTH'(prod_r[c]);
    end
    shifted = sum >>> FRAC_BITS;
    if (shifted > SatMax) begin
      res.value = VEC_WIDTH'(SatMax);
      res.sat   = 1'b1;
    end else if (shifted < SatMin) begin
      res.value = VEC_WIDTH'(SatMin);
      res.sat   = 1'b1;
    end else begin
      res.value = shifted[VEC_WIDTH-1:0];
      res.sat   = 1'b0;
    end
  end

endmodule
`default_nettype wire

/* rtl/matrix4_vector_transform_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_vector_transform_top: 4x4 fixed-point matrix times vector stream
// Data path: the input register loads on the accepting edge, then the product
// register in the row units, then the result register, which drives out_valid.
// Throughput: one word per cycle while out_ready stays high; every stage moves
// on whenever the next one does.
// Reset: synchronous active-low; clears the pipeline and loads the identity
// matrix into the row registers.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  m4vt_pkg::cfg_idx_t            cfg_index,
  input  logic [m4vt_pkg::ROW_WIDTH-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [m4vt_pkg::VEC_WIDTH-1:0] in_vx,
  input  logic signed [m4vt_pkg::VEC_WIDTH-1:0] in_vy,
  input  logic signed [m4vt_pkg::VEC_WIDTH-1:0] in_vz,
  input  logic signed [m4vt_pkg::VEC_WIDTH-1:0] in_vw,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [m4vt_pkg::VEC_WIDTH-1:0] out_rx,
  output logic signed [m4vt_pkg::VEC_WIDTH-1:0] out_ry,
  output logic signed [m4vt_pkg::VEC_WIDTH-1:0] out_rz,
  output logic signed [m4vt_pkg::VEC_WIDTH-1:0] out_rw,
  output logic                          out_saturated
);
  import m4vt_pkg::*;

  logic [ROW_WIDTH-1:0] matrix_r [NUM_ROWS];

  logic     a_valid_r;
  vec_t     vec_a_r;
  logic     b_valid_r;
  logic     out_valid_r;
  logic [NUM_ROWS-1:0][VEC_WIDTH-1:0] res_r;
  logic     sat_r;

  logic     c_adv;
  logic     b_ready;
  logic     a_ready;
  logic     unit_en;
  row_res_t row_res [NUM_ROWS];
  logic [NUM_ROWS-1:0] sat_vec;

  // Each stage moves on when it is empty or the stage after it moves on.
  assign c_adv   = !out_valid_r || out_ready;
  assign b_ready = !b_valid_r || c_adv;
  assign a_ready = !a_valid_r || b_ready;
  assign unit_en = a_valid_r && b_ready;

  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r[0] <= ROW0_RESET;
      matrix_r[1] <= ROW1_RESET;
      matrix_r[2] <= ROW2_RESET;
      matrix_r[3] <= ROW3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW0: matrix_r[0] <= cfg_wdata;
        CFG_ROW1: matrix_r[1] <= cfg_wdata;
        CFG_ROW2: matrix_r[2] <= cfg_wdata;
        CFG_ROW3: matrix_r[3] <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_adv) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      vec_a_r <= {in_vw, in_vz, in_vy, in_vx};
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    m4vt_row_unit u_row (
      .clk (clk),
      .en  (unit_en),
      .row (matrix_r[r]),
      .vec (vec_a_r),
      .res (row_res[r])
    );
    assign sat_vec[r] = row_res[r].sat;
  end

  always_ff @(posedge clk) begin
    if (b_valid_r && c_adv) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        res_r[r] <= row_res[r].value;
      end
      sat_r <= |sat_vec;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rx        = $signed(res_r[0]);
  assign out_ry        = $signed(res_r[1]);
  assign out_rz        = $signed(res_r[2]);
  assign out_rw        = $signed(res_r[3]);
  assign out_saturated = sat_r;

endmodule
`default_nettype wire

/* rtl/m4vt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// m4vt_checker: port-level checks for the matrix vector transform
// Watches the handshakes and result words at the top-level ports.
// ----------------------------------------------------------------------------
module m4vt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [m4vt_pkg::VEC_WIDTH-1:0] out_rx,
  input logic signed [m4vt_pkg::VEC_WIDTH-1:0] out_ry,
  input logic signed [m4vt_pkg::VEC_WIDTH-1:0] out_rz,
  input logic signed [m4vt_pkg::VEC_WIDTH-1:0] out_rw,
  input logic                          out_saturated
);
  import m4vt_pkg::*;

  localparam logic signed [VEC_WIDTH-1:0] PosRail = 16'sh7fff;
  localparam logic signed [VEC_WIDTH-1:0] NegRail = 16'sh8000;

  // A stalled result word must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rx) && $stable(out_ry)
      && $stable(out_rz) && $stable(out_rw) && $stable(out_saturated))
    else $error("result word changed while stalled");

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // The input side only stalls when a finished word is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty output register");

  // A flagged word must carry at least one component on a rail.
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_rx == PosRail) || (out_rx == NegRail) ||
      (out_ry == PosRail) || (out_ry == NegRail) ||
      (out_rz == PosRail) || (out_rz == NegRail) ||
      (out_rw == PosRail) || (out_rw == NegRail))
    else $error("saturation flag set with no clamped component");

endmodule

bind matrix4_vector_transform_top m4vt_checker u_m4vt_checker (.*);
`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stream test for matrix4_vector_transform_top
// A table of directed words and register writes runs first. Random words
// follow under several matrix settings and handshake pressure. Every result
// word is checked per field against a typed entry or fixed-point transform.
// ----------------------------------------------------------------------------
module testbench;
  import m4vt_pkg::*;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] vx;
    logic signed [VEC_WIDTH-1:0] vy;
    logic signed [VEC_WIDTH-1:0] vz;
    logic signed [VEC_WIDTH-1:0] vw;
  } vec_word_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] rx;
    logic signed [VEC_WIDTH-1:0] ry;
    logic signed [VEC_WIDTH-1:0] rz;
    logic signed [VEC_WIDTH-1:0] rw;
    logic                        saturated;
  } transform_t;

  typedef enum {STEP_WORD, STEP_WRITE} step_kind_t;
  typedef enum {MAT_FULL, MAT_SMALL, MAT_CORNER, MAT_MIXED} matrix_style_t;

  typedef struct {
    step_kind_t           kind;
    cfg_idx_t             idx;
    logic [ROW_WIDTH-1:0] data;
    vec_word_t            word;
    bit                   typed;
    transform_t           result;
  } stim_step_t;

  typedef struct {
    int            send_idle;
    int            recv_stall;
    matrix_style_t style;
  } phase_t;

  localparam int NUM_DIRECTED    = 24;
  localparam int WORDS_PER_PHASE = 100;
  localparam int MAX_GAP         = 40;
  localparam int DRAIN_CYCLES    = 8;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  cfg_idx_t             cfg_index = CFG_ROW0;
  logic [ROW_WIDTH-1:0] cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic signed [VEC_WIDTH-1:0] in_vx = '0;
  logic signed [VEC_WIDTH-1:0] in_vy = '0;
  logic signed [VEC_WIDTH-1:0] in_vz = '0;
  logic signed [VEC_WIDTH-1:0] in_vw = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [VEC_WIDTH-1:0] out_rx;
  logic signed [VEC_WIDTH-1:0] out_ry;
  logic signed [VEC_WIDTH-1:0] out_rz;
  logic signed [VEC_WIDTH-1:0] out_rw;
  logic                 out_saturated;

  // Local copy of the row registers, starting from the identity matrix.
  logic [ROW_WIDTH-1:0] matrix_rows [NUM_ROWS] =
    '{ROW0_RESET, ROW1_RESET, ROW2_RESET, ROW3_RESET};
  transform_t expected_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int words_sent     = 0;
  int rows_written   = 0;
  int results_seen   = 0;
  int saturated_seen = 0;

  // The index port is a two-bit enum, so a write to an index above the last
  // row cannot be expressed and is not part of the table.
  stim_step_t directed_steps [NUM_DIRECTED] = '{
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1}, 1'b1,
      '{16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 1'b0}},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sh8000, 16'sh7FFF, -16'sd1, 16'sd1}, 1'b1,
      '{16'sh8000, 16'sh7FFF, -16'sd1, 16'sd1, 1'b0}},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sh5555, 16'shAAAA, 16'sh0100, 16'shFF00},
      1'b1, '{16'sh5555, 16'shAAAA, 16'sh0100, 16'shFF00, 1'b0}},
    '{STEP_WRITE, CFG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_ROW1, 64'h8000_8000_8000_8000, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_ROW3, 64'h0, '0, 1'b0, '0},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      1'b1, '{16'sh7FFF, 16'sh8000, -16'sd512, 16'sd0, 1'b1}},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
      1'b1, '{16'sh8000, 16'sh7FFF, 16'sd512, 16'sd0, 1'b1}},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd127, -16'sd128, -16'sd1, 16'sd0, 1'b0}},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{-16'sd128, 16'sd128, 16'sd0, 16'sd0, 1'b0}},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sd100, -16'sd200, 16'sd300, -16'sd400},
      1'b0, '0},
    // Each row picks a different column, so a row reading the wrong element
    // or writing the wrong component shows up at once.
    '{STEP_WRITE, CFG_ROW0, 64'h0100_0000_0000_0000, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_ROW1, 64'h0000_0100_0000_0000, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_ROW2, 64'h0000_0000_0100_0000, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_ROW3, 64'h0000_0000_0000_0100, '0, 1'b0, '0},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sd1, 16'sd2, 16'sd3, 16'sd4}, 1'b1,
      '{16'sd4, 16'sd3, 16'sd2, 16'sd1, 1'b0}},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sh8000, 16'sd12345, -16'sd7, 16'sh7FFF},
      1'b1, '{16'sh7FFF, -16'sd7, 16'sd12345, 16'sh8000, 1'b0}},
    '{STEP_WRITE, CFG_ROW0, 64'h0080_FF80_0040_FFC0, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_ROW1, 64'h1234_8765_0001_FFFF, '0, 1'b0, '0},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sd3, -16'sd5, 16'sd7, -16'sd9}, 1'b0, '0},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000},
      1'b0, '0},
    '{STEP_WORD, CFG_ROW0, 64'h0, '{16'sd255, -16'sd255, 16'sd511, -16'sd511},
      1'b0, '0}
  };

  phase_t phases [4] = '{
    '{0,  0,  MAT_FULL},
    '{77, 0,  MAT_SMALL},
    '{0,  77, MAT_CORNER},
    '{14, 14, MAT_MIXED}
  };

  matrix4_vector_transform_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_vx         (in_vx),
    .in_vy         (in_vy),
    .in_vz         (in_vz),
    .in_vw         (in_vw),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rx        (out_rx),
    .out_ry        (out_ry),
    .out_rz        (out_rz),
    .out_rw        (out_rw),
    .out_saturated (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("matrix4_vector_transform_top test failed");
    $finish;
  end

  // Exact dot products, floored by the fraction shift, then clamped.
  function automatic transform_t transform_word(input vec_word_t word);
    logic signed [VEC_WIDTH-1:0]  lanes [NUM_COLS];
    logic signed [VEC_WIDTH-1:0]  dots [NUM_ROWS];
    logic signed [ELEM_WIDTH-1:0] elem;
    longint                       acc;
    transform_t                   res;
    int                           r;
    int                           c;
    lanes[0] = word.vx;
    lanes[1] = word.vy;
    lanes[2] = word.vz;
    lanes[3] = word.vw;
    res.saturated = 1'b0;
    for (r = 0; r < NUM_ROWS; r++) begin
      acc = 0;
      for (c = 0; c < NUM_COLS; c++) begin
        elem = matrix_rows[r][c*ELEM_WIDTH +: ELEM_WIDTH];
        acc += longint'(elem) * longint'(lanes[c]);
      end
      acc = acc >>> FRAC_BITS;
      if (acc > 32767) begin
        dots[r] = 16'sh7FFF;
        res.saturated = 1'b1;
      end else if (acc < -32768) begin
        dots[r] = 16'sh8000;
        res.saturated = 1'b1;
      end else begin
        dots[r] = acc[VEC_WIDTH-1:0];
      end
    end
    res.rx = dots[0];
    res.ry = dots[1];
    res.rz = dots[2];
    res.rw = dots[3];
    return res;
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] random_lane();
    logic [VEC_WIDTH-1:0] corner [5];
    corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    case ($urandom_range(3))
      0: return 16'($urandom_range(4095)) - 16'd2048;
      1: return corner[$urandom_range(4)];
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ROW_WIDTH-1:0] random_row(input matrix_style_t style);
    logic [ROW_WIDTH-1:0]  row;
    logic [ELEM_WIDTH-1:0] corner [5];
    matrix_style_t         pick;
    int                    c;
    corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0100};
    row = {$urandom, $urandom};
    for (c = 0; c < NUM_COLS; c++) begin
      pick = (style == MAT_MIXED) ? matrix_style_t'($urandom_range(2)) : style;
      case (pick)
        MAT_SMALL:  row[c*ELEM_WIDTH +: ELEM_WIDTH] = 16'($urandom_range(1023)) - 16'd512;
        MAT_CORNER: row[c*ELEM_WIDTH +: ELEM_WIDTH] = corner[$urandom_range(4)];
        default: ;
      endcase
    end
    return row;
  endfunction

  // Leaves the write enable high; the next word lowers it.
  task automatic write_row(input cfg_idx_t idx, input logic [ROW_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    matrix_rows[idx] = value;
    rows_written++;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_matrix(input matrix_style_t style);
    int r;
    in_valid <= 1'b0;
    wait_drained();
    for (r = 0; r < NUM_ROWS; r++) begin
      write_row(cfg_idx_t'(r), random_row(style));
    end
  endtask

  // The expectation is taken at the accepting edge, with the matrix as it
  // stands then; rows only change while nothing is in flight.
  task automatic send_word(input vec_word_t word, input bit typed,
                           input transform_t typed_result);
    cfg_we   <= 1'b0;
    in_valid <= 1'b1;
    in_vx    <= word.vx;
    in_vy    <= word.vy;
    in_vz    <= word.vz;
    in_vw    <= word.vw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(typed ? typed_result : transform_word(word));
    words_sent++;
  endtask

  task automatic check_field(input string name, input logic signed [VEC_WIDTH-1:0] want,
                             input logic signed [VEC_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    transform_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_saturated === 1'b1) saturated_seen++;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: rx=%0d ry=%0d rz=%0d rw=%0d",
               out_rx, out_ry, out_rz, out_rw);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("rx", want.rx, out_rx);
        check_field("ry", want.ry, out_ry);
        check_field("rz", want.rz, out_rz);
        check_field("rw", want.rw, out_rw);
        check_field("saturated", {{(VEC_WIDTH-1){1'b0}}, want.saturated},
                    {{(VEC_WIDTH-1){1'b0}}, out_saturated});
      end
    end
  end

  initial begin : stimulus
    vec_word_t word;
    int        gap;
    int        n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        in_valid <= 1'b0;
        wait_drained();
        write_row(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        send_word(directed_steps[i].word, directed_steps[i].typed,
                  directed_steps[i].result);
      end
    end

    foreach (phases[p]) begin
      send_idle_pct  = phases[p].send_idle;
      recv_stall_pct = phases[p].recv_stall;
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        // Twice per phase the sender holds off until every result is back,
        // then a fresh matrix goes in.
        if (n % (WORDS_PER_PHASE / 2) == 0) load_matrix(phases[p].style);
        word.vx = random_lane();
        word.vy = random_lane();
        word.vz = random_lane();
        word.vw = random_lane();
        send_word(word, 1'b0, '0);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Transformed %0d vector words over %0d row writes and four handshake phases.",
             words_sent, rows_written);
    $display("Checked %0d result words, %0d of them clamped.", results_seen, saturated_seen);
    if (errors == 0) begin
      $display("matrix4_vector_transform_top test passed");
    end else begin
      $display("matrix4_vector_transform_top test failed");
    end
    $finish;
  end

endmodule
